// ===== hdl/rled_pkg.sv =====
`default_nettype none

package rled_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CNT_BITS  = 6;

  localparam logic [BYTE_BITS-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_BITS-1:0] BYTE_ONES = 8'hFF;

  // header code in bits 7:6 of a header byte
  typedef enum logic [1:0] {
    CODE_LIT  = 2'b00,
    CODE_RUNV = 2'b01,
    CODE_ZERO = 2'b10,
    CODE_ONES = 2'b11
  } hdr_code_e;

  typedef enum logic [1:0] {
    VSEL_IN   = 2'b00,
    VSEL_ZERO = 2'b01,
    VSEL_ONES = 2'b10
  } val_sel_e;

  typedef struct packed {
    logic      hdr_take;  // load count from header byte
    logic      val_take;  // load run value
    val_sel_e  val_sel;
    logic      emit;      // load one byte into the output register
    logic      emit_lit;  // emitted byte is the incoming literal
  } cmd_t;

  typedef struct packed {
    logic      out_free;     // output register can take a byte this cycle
    logic      frame_end;    // next byte closes the frame
    logic      cnt_zero;
    logic      cnt_one;
    hdr_code_e in_code;
    logic      in_cnt_zero;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/rled_intf.sv =====
`default_nettype none

interface rled_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] comp_byte;

  modport source (output valid, output comp_byte, input ready);
  modport sink (input valid, input comp_byte, output ready);
endinterface

interface rled_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_last;
  logic       overrun;
  logic       run_last;

  modport source (output valid, output out_byte, output frame_last, output overrun,
                  output run_last, input ready);
  modport sink (input valid, input out_byte, input frame_last, input overrun,
                input run_last, output ready);
endinterface

interface rled_cfg_if #(
  parameter int unsigned LENGTH_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [LENGTH_BITS-1:0] frame_length;

  modport source (output valid, output frame_length, input ready);
  modport sink (input valid, input frame_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/rled_dp.sv =====
`default_nettype none

module rled_dp #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [7:0]             in_byte_i,
  input  wire logic                   cfg_fire_i,
  input  wire logic [LENGTH_BITS-1:0] cfg_data_i,
  input  wire logic                   out_ready_i,
  input  wire rled_pkg::cmd_t         cmd_i,
  output rled_pkg::sts_t              sts_o,
  output logic                        out_valid_o,
  output logic [7:0]                  out_byte_o,
  output logic                        frame_last_o,
  output logic                        overrun_o,
  output logic                        run_last_o
);
  import rled_pkg::*;

  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [BYTE_BITS-1:0]   val_q;
  logic [BYTE_BITS-1:0]   out_byte_q;
  logic                   last_q, ovr_q, rl_q;

  logic                   frame_end, cnt_zero, cnt_one;
  logic [BYTE_BITS-1:0]   emit_byte;
  logic [BYTE_BITS-1:0]   val_sel_byte;

  assign frame_end = (left_q[LENGTH_BITS-1:1] == '0);
  assign cnt_zero  = (cnt_q == '0);
  assign cnt_one   = (cnt_q == CNT_BITS'(1));
  assign emit_byte = cmd_i.emit_lit ? in_byte_i : val_q;

  always_comb begin
    case (cmd_i.val_sel)
      VSEL_ZERO: val_sel_byte = BYTE_ZERO;
      VSEL_ONES: val_sel_byte = BYTE_ONES;
      default:   val_sel_byte = in_byte_i;
    endcase
  end

  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.frame_end   = frame_end;
  assign sts_o.cnt_zero    = cnt_zero;
  assign sts_o.cnt_one     = cnt_one;
  assign sts_o.in_code     = hdr_code_e'(in_byte_i[7:6]);
  assign sts_o.in_cnt_zero = (in_byte_i[CNT_BITS-1:0] == '0);

  always_comb begin
    len_d       = len_q;
    left_d      = left_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_fire_i) begin
      // a zero length behaves as one
      len_d  = (cfg_data_i == '0) ? LENGTH_BITS'(1) : cfg_data_i;
      left_d = len_d;
      cnt_d  = '0;
    end else begin
      if (cmd_i.hdr_take) begin
        cnt_d = in_byte_i[CNT_BITS-1:0];
      end
      if (cmd_i.emit) begin
        out_valid_d = 1'b1;
        // drop the rest of the block at the frame boundary
        cnt_d  = frame_end ? '0 : cnt_q - CNT_BITS'(1);
        left_d = frame_end ? len_q : left_q - LENGTH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= LENGTH_BITS'(1);
      left_q      <= LENGTH_BITS'(1);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.val_take) begin
      val_q <= val_sel_byte;
    end
    if (cmd_i.emit) begin
      out_byte_q <= emit_byte;
      last_q     <= frame_end;
      ovr_q      <= frame_end && !cnt_zero && !cnt_one;
      rl_q       <= cmd_i.emit_lit || frame_end || cnt_one;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign frame_last_o = last_q;
  assign overrun_o    = ovr_q;
  assign run_last_o   = rl_q;

endmodule

`default_nettype wire

// ===== hdl/rled_ctrl.sv =====
`default_nettype none

module rled_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           cfg_fire_i,
  input  wire rled_pkg::sts_t sts_i,
  output rled_pkg::cmd_t      cmd_o
);
  import rled_pkg::*;

  typedef enum logic [3:0] {
    ST_HDR = 4'b0001,
    ST_LIT = 4'b0010,
    ST_VAL = 4'b0100,
    ST_RUN = 4'b1000
  } state_e;

  state_e st_q, st_d;
  logic   in_fire;

  assign in_ready_o = sts_i.out_free && (st_q != ST_RUN);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    st_d  = st_q;
    cmd_o = '{hdr_take: 1'b0, val_take: 1'b0, val_sel: VSEL_IN, emit: 1'b0,
              emit_lit: 1'b0};
    unique case (st_q)
      ST_HDR: begin
        if (in_fire) begin
          unique case (sts_i.in_code)
            CODE_LIT: begin
              cmd_o.hdr_take = 1'b1;
              st_d = sts_i.in_cnt_zero ? ST_HDR : ST_LIT;
            end
            CODE_RUNV: begin
              cmd_o.hdr_take = 1'b1;
              st_d = ST_VAL;
            end
            default: begin
              if (!sts_i.in_cnt_zero) begin
                cmd_o.hdr_take = 1'b1;
                cmd_o.val_take = 1'b1;
                cmd_o.val_sel  = (sts_i.in_code == CODE_ZERO) ? VSEL_ZERO : VSEL_ONES;
                st_d = ST_RUN;
              end
            end
          endcase
        end
      end
      ST_LIT: begin
        if (in_fire) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_lit = 1'b1;
          if (sts_i.frame_end || sts_i.cnt_one) begin
            st_d = ST_HDR;
          end
        end
      end
      ST_VAL: begin
        if (in_fire) begin
          // a zero-length run still swallows its value byte
          if (sts_i.cnt_zero) begin
            st_d = ST_HDR;
          end else begin
            cmd_o.val_take = 1'b1;
            st_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.frame_end || sts_i.cnt_one) begin
            st_d = ST_HDR;
          end
        end
      end
      default: st_d = ST_HDR;
    endcase
    if (cfg_fire_i) begin
      st_d  = ST_HDR;
      cmd_o = '{hdr_take: 1'b0, val_take: 1'b0, val_sel: VSEL_IN, emit: 1'b0,
                emit_lit: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_HDR;
    end else begin
      st_q <= st_d;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(st_q))
    else $error("state register not one-hot");
  a_run_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) |-> !sts_i.cnt_zero)
    else $error("run state with empty count");
  a_lit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LIT) |-> !sts_i.cnt_zero)
    else $error("literal state with empty count");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("emit while output register is held");
`endif

endmodule

`default_nettype wire

// ===== hdl/rle_extended_byte_decoder_top.sv =====
// Channel  Dir  Payload                                       Transfer
// comp_i   in   comp_byte[7:0]                                valid & ready
// res_o    out  out_byte[7:0], frame_last, overrun, run_last  valid & ready
// cfg_i    in   frame_length[LENGTH_BITS-1:0]                 valid & ready (ready tied high)
//
// Header byte: no output. Literal byte: one result.
// Run: value byte taken, then one result per cycle while res_o is ready, up to 63 results,
// with comp_i held off; the single output register and the run counter set this.
// A stall on res_o holds the output register and backs up into comp_i.
// Reset is asynchronous, active low; no clearing pass. A frame_length write aborts the frame.
`default_nettype none

module rle_extended_byte_decoder_top #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rled_in_if.sink   comp_i,
  rled_out_if.source res_o,
  rled_cfg_if.sink  cfg_i
);
  import rled_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  rled_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (comp_i.valid),
    .in_ready_o (comp_i.ready),
    .cfg_fire_i (cfg_fire),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rled_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (comp_i.comp_byte),
    .cfg_fire_i   (cfg_fire),
    .cfg_data_i   (cfg_i.frame_length),
    .out_ready_i  (res_o.ready),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (res_o.valid),
    .out_byte_o   (res_o.out_byte),
    .frame_last_o (res_o.frame_last),
    .overrun_o    (res_o.overrun),
    .run_last_o   (res_o.run_last)
  );

endmodule

`default_nettype wire

// ===== bench/tb_rle_extended_byte_decoder_top.sv =====
`timescale 1ns / 100ps

module tb_rle_extended_byte_decoder_top;
  import rled_pkg::*;

  localparam int unsigned LEN_BITS    = 16;
  localparam int unsigned WDOG_LIMIT  = 5000;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned ITEMS_PHASE = 46;

  typedef enum logic [1:0] {
    DEC_HEADER  = 2'd0,
    DEC_LITERAL = 2'd1,
    DEC_RUNVAL  = 2'd2
  } dec_phase_e;

  typedef enum logic [1:0] {
    RX_OPEN     = 2'd0,
    RX_RANDOM   = 2'd1,
    RX_PERIODIC = 2'd2,
    RX_CHOKE    = 2'd3
  } rx_mode_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
    logic       overrun;
    logic       run_last;
  } dec_byte_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rled_in_if  comp_if ();
  rled_out_if res_if ();
  rled_cfg_if #(.LENGTH_BITS(LEN_BITS)) cfg_if ();

  rle_extended_byte_decoder_top #(
    .LENGTH_BITS(LEN_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .comp_i(comp_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  always #4 clk_i = ~clk_i;

  // decoder state as the block should hold it
  logic [LEN_BITS-1:0] dec_frame_len;
  int unsigned         dec_left;
  int unsigned         dec_pend;
  dec_phase_e          dec_phase;

  dec_byte_t   out_due_q[$];
  int unsigned err_cnt  = 0;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned idle_cyc = 0;
  int unsigned rx_cyc   = 0;
  rx_mode_e    rx_mode  = RX_OPEN;

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int unsigned eff_frame_len();
    return (dec_frame_len == '0) ? 1 : int'(dec_frame_len);
  endfunction

  task automatic load_frame_len(input logic [LEN_BITS-1:0] len);
    dec_frame_len = len;
    dec_left      = eff_frame_len();
    dec_phase     = DEC_HEADER;
    dec_pend      = 0;
  endtask

  task automatic emit_run_bytes(input logic [7:0] val, input int unsigned cnt);
    dec_byte_t r;
    logic      at_end;
    while (cnt > 0) begin
      cnt--;
      at_end       = (dec_left <= 1);
      r.out_byte   = val;
      r.frame_last = at_end;
      r.overrun    = at_end && (cnt > 0);
      r.run_last   = at_end || (cnt == 0);
      out_due_q.push_back(r);
      if (at_end) begin
        // drop the rest of the run, new frame starts
        dec_left = eff_frame_len();
        break;
      end
      dec_left--;
    end
    dec_phase = DEC_HEADER;
    dec_pend  = 0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    dec_byte_t   r;
    int unsigned rest;
    logic        at_end;
    case (dec_phase)
      DEC_LITERAL: begin
        rest         = (dec_pend > 0) ? dec_pend - 1 : 0;
        at_end       = (dec_left <= 1);
        r.out_byte   = b;
        r.frame_last = at_end;
        r.overrun    = at_end && (rest > 0);
        r.run_last   = 1'b1;
        out_due_q.push_back(r);
        if (at_end) begin
          dec_left = eff_frame_len();
          rest     = 0;
        end else begin
          dec_left--;
        end
        dec_pend = rest;
        if (rest == 0) dec_phase = DEC_HEADER;
      end
      DEC_RUNVAL: emit_run_bytes(b, dec_pend);
      default: begin
        case (hdr_code_e'(b[7:6]))
          CODE_LIT: begin
            dec_pend  = b[5:0];
            dec_phase = (b[5:0] != 0) ? DEC_LITERAL : DEC_HEADER;
          end
          CODE_RUNV: begin
            dec_pend  = b[5:0];
            dec_phase = DEC_RUNVAL;
          end
          CODE_ZERO: emit_run_bytes(BYTE_ZERO, b[5:0]);
          default:   emit_run_bytes(BYTE_ONES, b[5:0]);
        endcase
      end
    endcase
  endtask

  // bursts of transfers with random gaps in between
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        comp_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    comp_if.valid     <= 1'b1;
    comp_if.comp_byte <= b;
    @(posedge clk_i);
    while (!comp_if.ready) @(posedge clk_i);
    decode_byte(b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    comp_if.valid <= 1'b0;
    burst_left = 0;
    while (out_due_q.size() != 0) @(negedge clk_i);
    // a trailing header produces nothing, give it time to settle
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_frame_len(input logic [LEN_BITS-1:0] len);
    wait_drained();
    cfg_if.valid        <= 1'b1;
    cfg_if.frame_length <= len;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    load_frame_len(len);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_block();
    int unsigned kind;
    int unsigned cnt;
    kind = $urandom_range(0, 99);
    cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
    if (kind < 50) begin
      send_byte({CODE_LIT, 6'(cnt)});
      repeat (cnt) send_byte(8'($urandom));
    end else if (kind < 72) begin
      send_byte({CODE_RUNV, 6'(cnt)});
      send_byte(8'($urandom));
    end else if (kind < 90) begin
      send_byte({($urandom_range(0, 1) != 0) ? CODE_ONES : CODE_ZERO, 6'(cnt)});
    end else begin
      // stray byte, breaks the block structure
      send_byte(8'($urandom));
    end
  endtask

  task automatic test_default_length();
    // frame of one byte: literal block and run both cut at once
    send_byte({CODE_LIT, 6'd2});
    send_byte(8'h11);
    send_byte({CODE_LIT, 6'd0});
    send_byte({CODE_ONES, 6'd3});
  endtask

  task automatic test_block_types();
    write_frame_len(16'd10);
    send_byte({CODE_LIT, 6'd0});
    send_byte({CODE_RUNV, 6'd0});
    send_byte(8'h5A);
    send_byte({CODE_ZERO, 6'd0});
    send_byte({CODE_ONES, 6'd0});
    send_byte({CODE_LIT, 6'd3});
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte({CODE_RUNV, 6'd5});
    send_byte(8'h7E);
    send_byte({CODE_ZERO, 6'd2});
    send_byte({CODE_ONES, 6'd4});
    send_byte({CODE_RUNV, 6'd63});
    send_byte(8'h33);
    send_byte({CODE_ZERO, 6'd63});
    send_byte({CODE_ONES, 6'd63});
  endtask

  task automatic test_zero_length();
    write_frame_len('0);
    send_byte({CODE_ZERO, 6'd3});
    send_byte({CODE_RUNV, 6'd1});
    send_byte(8'h99);
  endtask

  task automatic test_random_traffic();
    logic [LEN_BITS-1:0] lens[8];
    int unsigned         target;
    lens = '{16'd1, 16'd0, 16'd2, 16'd5, 16'd17, 16'd64, 16'hFFFF,
             LEN_BITS'($urandom_range(3, 300))};
    foreach (lens[i]) begin
      write_frame_len(lens[i]);
      target = items_sent + ITEMS_PHASE;
      while (items_sent < target) begin
        send_block();
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    dec_byte_t due;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (out_due_q.size() == 0) begin
        report_err($sformatf("unexpected byte %02h", res_if.out_byte));
      end else begin
        due = out_due_q.pop_front();
        if (res_if.out_byte !== due.out_byte)
          report_err($sformatf("out_byte %02h, want %02h", res_if.out_byte, due.out_byte));
        if (res_if.frame_last !== due.frame_last)
          report_err($sformatf("frame_last %b, want %b", res_if.frame_last, due.frame_last));
        if (res_if.overrun !== due.overrun)
          report_err($sformatf("overrun %b, want %b", res_if.overrun, due.overrun));
        if (res_if.run_last !== due.run_last)
          report_err($sformatf("run_last %b, want %b", res_if.run_last, due.run_last));
      end
    end
  end

  // receiver back-pressure, pattern changes every so often
  always @(negedge clk_i) begin
    rx_cyc++;
    if (rx_cyc % 150 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     res_if.ready <= 1'b1;
      RX_RANDOM:   res_if.ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: res_if.ready <= ((rx_cyc % 7) > 2);
      default:     res_if.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((comp_if.valid && comp_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cyc = 0;
      end else begin
        idle_cyc++;
      end
      if (idle_cyc >= WDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    comp_if.valid       = 1'b0;
    comp_if.comp_byte   = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.frame_length = '0;
    items_sent = 0;
    burst_left = 0;
    load_frame_len(LEN_BITS'(1));
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_length();
    test_block_types();
    test_zero_length();
    test_random_traffic();

    comp_if.valid <= 1'b0;
    while (out_due_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
